// File: design/bpml_pkg.sv
// shared constants for the bilinear pedal map lookup unit
`timescale 1ns / 1ps
package bpml_pkg;

  // item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // configuration register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_SPEED_LOW    = 3'd0;
  localparam logic [2:0] REG_SPEED_HIGH   = 3'd1;
  localparam logic [2:0] REG_ACCEL_LOW    = 3'd2;
  localparam logic [2:0] REG_ACCEL_HIGH   = 3'd3;
  localparam logic [2:0] REG_SPEED_POINTS = 3'd4;
  localparam logic [2:0] REG_ACCEL_POINTS = 3'd5;
  localparam logic [2:0] REG_TABLE_READY  = 3'd6;

  // grid store geometry
  localparam int GRID_AW    = 12;
  localparam int GRID_DEPTH = 1 << GRID_AW;

  // default axis limits
  localparam int MAX_SPEED_POINTS_DEF = 64;
  localparam int MAX_ACCEL_POINTS_DEF = 64;

  // fixed point constants
  localparam logic [14:0] ONE_Q14 = 15'd16384;
  // fallback brake: divide by ten as multiply by ceil(2^22 / 10) and shift
  localparam int          FB_SHIFT       = 22;
  localparam logic [18:0] FB_RECIP       = 19'd419431;
  // at or above this negated accel the fallback brake is at full scale
  localparam logic [15:0] FB_BRAKE_LIMIT = 16'd2560;
  // accel at or above this gives full fallback throttle
  localparam logic signed [15:0] FB_THR_LIMIT = 16'sd256;

endpackage

// File: design/bilinear_pedal_map_lookup_unit.sv
// bilinear pedal map lookup: speed and acceleration to throttle and brake
`timescale 1ns / 1ps
// One item is accepted in every clock cycle; busy is never high. A query item
// gives one result, a write item none. A result is shown on the result ports
// for one cycle with done high, and the receiver cannot stall it. Each item
// passes the input and scaling stages, the two pipelined restoring dividers
// that scale speed and acceleration to grid indices, and the address, memory
// read, two weight multiplies, sum and output stages. Grid writes travel the
// same pipeline and land in the two grid copies at the memory stage, so
// queries see writes in item order. Config must be written over the APB port
// only while no item is in flight, a rule for the user that the block itself
// does not enforce.
module bilinear_pedal_map_lookup_unit #(
  parameter int MAX_SPEED_POINTS = bpml_pkg::MAX_SPEED_POINTS_DEF,
  parameter int MAX_ACCEL_POINTS = bpml_pkg::MAX_ACCEL_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // command side
  input  logic               start,
  output logic               busy,
  input  logic               opcode,
  input  logic signed [15:0] speed_in,
  input  logic signed [15:0] accel_in,
  input  logic [11:0]        entry_index,
  input  logic signed [15:0] entry_value,
  // result side
  output logic               done,
  output logic signed [15:0] control_out,
  output logic [14:0]        throttle_out,
  output logic [14:0]        brake_out,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int MAXP = (MAX_SPEED_POINTS > MAX_ACCEL_POINTS) ?
                        MAX_SPEED_POINTS : MAX_ACCEL_POINTS;
  localparam int PTW  = $clog2(MAXP);
  localparam int QW   = PTW + 8;
  localparam int PW   = 16 + PTW;
  localparam int RW   = (2 * PTW + 2 > bpml_pkg::GRID_AW) ? 2 * PTW + 2 :
                        bpml_pkg::GRID_AW;

  typedef struct packed {
    logic               valid;
    logic               op;
    logic [11:0]        idx;
    logic signed [15:0] val;
    logic signed [15:0] fb_ctl;
    logic [14:0]        fb_thr;
    logic [14:0]        fb_brk;
  } side_t;

  // configuration registers
  logic signed [15:0] speed_low, speed_high, accel_low, accel_high;
  logic [6:0]         speed_points, accel_points;
  logic               table_ready;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_low    <= 16'sd0;
      speed_high   <= 16'sd7680;
      accel_low    <= -16'sd2048;
      accel_high   <= 16'sd1024;
      speed_points <= 7'd64;
      accel_points <= 7'd64;
      table_ready  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        bpml_pkg::REG_SPEED_LOW:    speed_low    <= pwdata[15:0];
        bpml_pkg::REG_SPEED_HIGH:   speed_high   <= pwdata[15:0];
        bpml_pkg::REG_ACCEL_LOW:    accel_low    <= pwdata[15:0];
        bpml_pkg::REG_ACCEL_HIGH:   accel_high   <= pwdata[15:0];
        bpml_pkg::REG_SPEED_POINTS: speed_points <= pwdata[6:0];
        bpml_pkg::REG_ACCEL_POINTS: accel_points <= pwdata[6:0];
        bpml_pkg::REG_TABLE_READY:  table_ready  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[4:2])
      bpml_pkg::REG_SPEED_LOW:    prdata = {{16{speed_low[15]}}, speed_low};
      bpml_pkg::REG_SPEED_HIGH:   prdata = {{16{speed_high[15]}}, speed_high};
      bpml_pkg::REG_ACCEL_LOW:    prdata = {{16{accel_low[15]}}, accel_low};
      bpml_pkg::REG_ACCEL_HIGH:   prdata = {{16{accel_high[15]}}, accel_high};
      bpml_pkg::REG_SPEED_POINTS: prdata = {25'd0, speed_points};
      bpml_pkg::REG_ACCEL_POINTS: prdata = {25'd0, accel_points};
      bpml_pkg::REG_TABLE_READY:  prdata = {31'd0, table_ready};
      default:                    prdata = 32'd0;
    endcase
  end

  // effective point counts minus one, and axis spans
  logic [8:0]     sp9, ap9;
  logic [PTW-1:0] spd_m1, acc_m1;
  logic [15:0]    den_s, den_a;
  logic           span_s, span_a;

  always_comb begin
    sp9 = {2'b00, speed_points};
    ap9 = {2'b00, accel_points};
    if (sp9 == 9'd0) spd_m1 = '0;
    else if (sp9 > 9'(MAX_SPEED_POINTS)) spd_m1 = PTW'(MAX_SPEED_POINTS - 1);
    else spd_m1 = PTW'(sp9 - 9'd1);
    if (ap9 == 9'd0) acc_m1 = '0;
    else if (ap9 > 9'(MAX_ACCEL_POINTS)) acc_m1 = PTW'(MAX_ACCEL_POINTS - 1);
    else acc_m1 = PTW'(ap9 - 9'd1);
    span_s = speed_high > speed_low;
    span_a = accel_high > accel_low;
    den_s  = span_s ? 16'(speed_high - speed_low) : 16'd1;
    den_a  = span_a ? 16'(accel_high - accel_low) : 16'd1;
  end

  // input stage
  logic               s1_valid, s1_op;
  logic signed [15:0] s1_spd, s1_acc, s1_val;
  logic [11:0]        s1_idx;

  always_ff @(posedge clk) begin
    s1_op  <= opcode;
    s1_spd <= speed_in;
    s1_acc <= accel_in;
    s1_idx <= entry_index;
    s1_val <= entry_value;
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= start && !busy;
  end

  // scaling stage: clamp, offset, times points minus one; fallback mapping
  logic signed [15:0] clp_s, clp_a;
  logic signed [16:0] dif_s, dif_a;
  logic [15:0]        off_s, off_a;
  logic [PW-1:0]      prod_s, prod_a;
  logic [14:0]        fb_thr, fb_brk;
  logic signed [15:0] fb_ctl;
  logic [16:0]        fb_neg;
  logic [17:0]        fb_x;
  logic [36:0]        fb_p;

  always_comb begin
    clp_s  = (s1_spd < speed_high) ? s1_spd : speed_high;
    if (clp_s < speed_low) clp_s = speed_low;
    clp_a  = (s1_acc < accel_high) ? s1_acc : accel_high;
    if (clp_a < accel_low) clp_a = accel_low;
    dif_s  = 17'(clp_s) - 17'(speed_low);
    dif_a  = 17'(clp_a) - 17'(accel_low);
    off_s  = span_s ? dif_s[15:0] : 16'd0;
    off_a  = span_a ? dif_a[15:0] : 16'd0;
    prod_s = PW'(off_s) * PW'(spd_m1);
    prod_a = PW'(off_a) * PW'(acc_m1);
    // fallback linear mapping of unclamped acceleration
    fb_neg = 17'd0 - {s1_acc[15], s1_acc};
    fb_x   = {fb_neg[11:0], 6'd0} + 18'd5;
    fb_p   = 37'(fb_x) * 37'(bpml_pkg::FB_RECIP);
    if (s1_acc > 16'sd0) begin
      fb_brk = 15'd0;
      if (s1_acc >= bpml_pkg::FB_THR_LIMIT) fb_thr = bpml_pkg::ONE_Q14;
      else fb_thr = {1'b0, s1_acc[7:0], 6'd0};
    end else begin
      fb_thr = 15'd0;
      if (fb_neg[15:0] >= bpml_pkg::FB_BRAKE_LIMIT) fb_brk = bpml_pkg::ONE_Q14;
      else fb_brk = fb_p[bpml_pkg::FB_SHIFT+14:bpml_pkg::FB_SHIFT];
    end
    fb_ctl = 16'({1'b0, fb_thr}) - 16'({1'b0, fb_brk});
  end

  // divider pipeline, element 0 is the scaling stage register
  side_t       dv_side [QW+1];
  logic [15:0] rem_s   [QW+1];
  logic [15:0] rem_a   [QW+1];
  logic [QW-1:0] low_s [QW+1];
  logic [QW-1:0] low_a [QW+1];
  logic [QW-1:0] quo_s [QW+1];
  logic [QW-1:0] quo_a [QW+1];

  always_ff @(posedge clk) begin
    dv_side[0].valid  <= s1_valid;
    dv_side[0].op     <= s1_op;
    dv_side[0].idx    <= s1_idx;
    dv_side[0].val    <= s1_val;
    dv_side[0].fb_ctl <= fb_ctl;
    dv_side[0].fb_thr <= fb_thr;
    dv_side[0].fb_brk <= fb_brk;
    rem_s[0] <= prod_s[PW-1:PTW];
    rem_a[0] <= prod_a[PW-1:PTW];
    low_s[0] <= {prod_s[PTW-1:0], 8'd0};
    low_a[0] <= {prod_a[PTW-1:0], 8'd0};
    quo_s[0] <= '0;
    quo_a[0] <= '0;
    if (rst) dv_side[0].valid <= 1'b0;
  end

  // one quotient bit per stage on each axis
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [16:0] r2_s, r2_a, sub_s, sub_a;
    logic        ge_s, ge_a;

    always_comb begin
      r2_s  = {rem_s[k], low_s[k][QW-1]};
      r2_a  = {rem_a[k], low_a[k][QW-1]};
      sub_s = r2_s - {1'b0, den_s};
      sub_a = r2_a - {1'b0, den_a};
      ge_s  = r2_s >= {1'b0, den_s};
      ge_a  = r2_a >= {1'b0, den_a};
    end

    always_ff @(posedge clk) begin
      dv_side[k+1] <= dv_side[k];
      rem_s[k+1]   <= ge_s ? sub_s[15:0] : r2_s[15:0];
      rem_a[k+1]   <= ge_a ? sub_a[15:0] : r2_a[15:0];
      low_s[k+1]   <= {low_s[k][QW-2:0], 1'b0};
      low_a[k+1]   <= {low_a[k][QW-2:0], 1'b0};
      quo_s[k+1]   <= {quo_s[k][QW-2:0], ge_s};
      quo_a[k+1]   <= {quo_a[k][QW-2:0], ge_a};
      if (rst) dv_side[k+1].valid <= 1'b0;
    end
  end

  // address stage: neighbor rows and columns, grid addresses, weights
  logic [PTW-1:0] s0, s1, a0, a1;
  logic [7:0]     ds, da;
  logic [PTW:0]   na;
  logic [RW-1:0]  row0, row1, full00, full01, full10, full11;

  always_comb begin
    s0     = quo_s[QW][QW-1:8];
    a0     = quo_a[QW][QW-1:8];
    ds     = quo_s[QW][7:0];
    da     = quo_a[QW][7:0];
    s1     = (({1'b0, s0} + 1'b1) < {1'b0, spd_m1}) ? PTW'(s0 + 1'b1) : spd_m1;
    a1     = (({1'b0, a0} + 1'b1) < {1'b0, acc_m1}) ? PTW'(a0 + 1'b1) : acc_m1;
    na     = {1'b0, acc_m1} + 1'b1;
    row0   = RW'(s0) * RW'(na);
    row1   = RW'(s1) * RW'(na);
    full00 = row0 + RW'(a0);
    full01 = row0 + RW'(a1);
    full10 = row1 + RW'(a0);
    full11 = row1 + RW'(a1);
  end

  side_t       ad_side;
  logic [11:0] ad_00, ad_01, ad_10, ad_11;
  logic [8:0]  ad_ws0, ad_ws1, ad_wa0, ad_wa1;

  always_ff @(posedge clk) begin
    ad_side <= dv_side[QW];
    ad_00   <= full00[11:0];
    ad_01   <= full01[11:0];
    ad_10   <= full10[11:0];
    ad_11   <= full11[11:0];
    ad_ws0  <= 9'd256 - {1'b0, ds};
    ad_ws1  <= {1'b0, ds};
    ad_wa0  <= 9'd256 - {1'b0, da};
    ad_wa1  <= {1'b0, da};
    if (rst) ad_side.valid <= 1'b0;
  end

  // grid store: two copies, each read at two addresses, written together
  logic signed [15:0] grid_lo [bpml_pkg::GRID_DEPTH];
  logic signed [15:0] grid_hi [bpml_pkg::GRID_DEPTH];
  side_t              rd_side;
  logic signed [15:0] v00, v01, v10, v11;
  logic [8:0]         rd_ws0, rd_ws1, rd_wa0, rd_wa1;

  always_ff @(posedge clk) begin
    if (ad_side.valid && ad_side.op == bpml_pkg::OP_WRITE) begin
      grid_lo[ad_side.idx] <= ad_side.val;
      grid_hi[ad_side.idx] <= ad_side.val;
    end
    v00 <= grid_lo[ad_00];
    v01 <= grid_lo[ad_01];
    v10 <= grid_hi[ad_10];
    v11 <= grid_hi[ad_11];
  end

  always_ff @(posedge clk) begin
    rd_side <= ad_side;
    rd_ws0  <= ad_ws0;
    rd_ws1  <= ad_ws1;
    rd_wa0  <= ad_wa0;
    rd_wa1  <= ad_wa1;
    if (rst) rd_side.valid <= 1'b0;
  end

  // first weight multiply: speed weights
  side_t              p1_side;
  logic signed [25:0] p1_00, p1_01, p1_10, p1_11;
  logic [8:0]         p1_wa0, p1_wa1;

  always_ff @(posedge clk) begin
    p1_side <= rd_side;
    p1_00   <= 26'(v00) * 26'($signed({1'b0, rd_ws0}));
    p1_01   <= 26'(v01) * 26'($signed({1'b0, rd_ws0}));
    p1_10   <= 26'(v10) * 26'($signed({1'b0, rd_ws1}));
    p1_11   <= 26'(v11) * 26'($signed({1'b0, rd_ws1}));
    p1_wa0  <= rd_wa0;
    p1_wa1  <= rd_wa1;
    if (rst) p1_side.valid <= 1'b0;
  end

  // second weight multiply: accel weights
  side_t              p2_side;
  logic signed [35:0] p2_00, p2_01, p2_10, p2_11;

  always_ff @(posedge clk) begin
    p2_side <= p1_side;
    p2_00   <= 36'(p1_00) * 36'($signed({1'b0, p1_wa0}));
    p2_01   <= 36'(p1_01) * 36'($signed({1'b0, p1_wa1}));
    p2_10   <= 36'(p1_10) * 36'($signed({1'b0, p1_wa0}));
    p2_11   <= 36'(p1_11) * 36'($signed({1'b0, p1_wa1}));
    if (rst) p2_side.valid <= 1'b0;
  end

  // sum of the four corners
  side_t              sm_side;
  logic signed [37:0] sm_sum;

  always_ff @(posedge clk) begin
    sm_side <= p2_side;
    sm_sum  <= 38'(p2_00) + 38'(p2_01) + 38'(p2_10) + 38'(p2_11);
    if (rst) sm_side.valid <= 1'b0;
  end

  // round half up, saturate, split into throttle and brake
  logic signed [37:0] rnd;
  logic signed [21:0] rsh;
  logic signed [15:0] g_ctl;
  logic [14:0]        g_thr, g_brk;
  logic signed [16:0] g_neg;

  always_comb begin
    rnd = sm_sum + 38'sd32768;
    rsh = 22'(rnd >>> 16);
    if (rsh > 22'sd32767)       g_ctl = 16'sd32767;
    else if (rsh < -22'sd32768) g_ctl = -16'sd32768;
    else                        g_ctl = rsh[15:0];
    g_neg = 17'sd0 - 17'(g_ctl);
    g_thr = (g_ctl > 16'sd0) ? g_ctl[14:0] : 15'd0;
    if (g_ctl >= 16'sd0)           g_brk = 15'd0;
    else if (g_neg > 17'sd32767)   g_brk = 15'd32767;
    else                           g_brk = g_neg[14:0];
  end

  always_ff @(posedge clk) begin
    if (table_ready) begin
      control_out  <= g_ctl;
      throttle_out <= g_thr;
      brake_out    <= g_brk;
    end else begin
      control_out  <= sm_side.fb_ctl;
      throttle_out <= sm_side.fb_thr;
      brake_out    <= sm_side.fb_brk;
    end
    if (rst) done <= 1'b0;
    else     done <= sm_side.valid && sm_side.op == bpml_pkg::OP_QUERY;
  end

endmodule

// File: design/bpml_check.sv
// port level checks for the bilinear pedal map lookup unit
`timescale 1ns / 1ps
module bpml_check (
  input logic               clk,
  input logic               rst,
  input logic               busy,
  input logic               done,
  input logic signed [15:0] control_out,
  input logic [14:0]        throttle_out,
  input logic [14:0]        brake_out
);

  // an item is taken in every cycle
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  // reset clears the result strobe
  a_reset_done: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe after reset");

  // throttle and brake never both applied when a result is shown
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> (throttle_out == 15'd0 || brake_out == 15'd0))
    else $error("throttle and brake both set");

  // a positive control is all throttle
  a_pos_split: assert property (@(posedge clk) disable iff (rst)
    (done && control_out > 16'sd0) |->
      (throttle_out == control_out[14:0] && brake_out == 15'd0))
    else $error("positive control split wrong");

  // a negative control is all brake
  a_neg_split: assert property (@(posedge clk) disable iff (rst)
    (done && control_out < 16'sd0) |->
      (throttle_out == 15'd0 && brake_out != 15'd0))
    else $error("negative control split wrong");

endmodule

bind bilinear_pedal_map_lookup_unit bpml_check u_bpml_check (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .done         (done),
  .control_out  (control_out),
  .throttle_out (throttle_out),
  .brake_out    (brake_out)
);
